FILE: rtl/gacs_pkg.sv
// Shared types, constants and arithmetic helpers of the amp and cabinet simulator.
package gacs_pkg;

  localparam int DELAY_LENGTH_DEF = 1024;

  localparam int SAMPLE_W = 24;   // Q1.23 sample
  localparam int X_W      = 26;   // lane input, room for left plus right
  localparam int XB_W     = 27;   // lane input plus bias
  localparam int ST_W     = 40;   // saturated internal state
  localparam int ACC_W    = 72;   // product accumulator
  localparam int OPA_W    = 42;   // wide multiplier operand
  localparam int OPB_W    = 28;   // narrow multiplier operand
  localparam int SPLIT    = 21;   // low half of the wide operand
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DELAY_W  = 10;   // tap delay field width

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MIXES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MODE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE   = 3'd7;

  // Mode bits inside tap_delays_and_mode
  localparam int MODE_SOFT_BIT   = 20;
  localparam int MODE_STEREO_BIT = 21;

  typedef struct packed {
    logic [26:0]        drive_gain;
    logic signed [16:0] bias_offset;
    logic [19:0]        clip_level;
    logic [23:0]        output_gain;
    logic [31:0]        smoothing_coefs;
    logic [31:0]        tap_mixes;
    logic [21:0]        tap_delays_and_mode;
    logic [31:0]        resonance_coefs;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic mono;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

  typedef enum logic [4:0] {
    L_CLEAR, L_IDLE,
    L_DRV, L_DRV_FIN,
    L_SVF0, L_SVF0_FIN, L_SVF1, L_SVF1_FIN, L_SVF2, L_SVF2_FIN,
    L_SHAPE, L_DIV, L_DIV_FIN,
    L_WRITE, L_RED1, L_ADDR2, L_RED2,
    L_MIX1, L_MIX2, L_MIX_FIN,
    L_LP0A, L_LP0B, L_LP0_FIN, L_LPK, L_LPK_FIN,
    L_DC, L_DC_FIN, L_DONE
  } lane_state_t;

  // Round half up, then arithmetic shift right by n
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x,
                                                   input int n);
    logic signed [ACC_W-1:0] half;
    half = '0;
    half[n-1] = 1'b1;
    return (x + half) >>> n;
  endfunction

  function automatic logic signed [ST_W-1:0] sat40(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(ST_W-1){1'b1}}}));
    lo = -hi - ACC_W'(signed'(2'sb01));
    if (x > hi) return ST_W'(hi);
    else if (x < lo) return ST_W'(lo);
    else return ST_W'(x);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    lo = -hi - ACC_W'(signed'(2'sb01));
    if (x > hi) return SAMPLE_W'(hi);
    else if (x < lo) return SAMPLE_W'(lo);
    else return SAMPLE_W'(x);
  endfunction

endpackage

FILE: rtl/gacs_in_if.sv
// Input frame channel: stereo sample pair with valid/ready.
interface gacs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gacs_pkg::SAMPLE_W-1:0]   left_sample;
  logic signed [gacs_pkg::SAMPLE_W-1:0]   right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

FILE: rtl/gacs_out_if.sv
// Result frame channel: stereo output pair with valid/ready.
interface gacs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gacs_pkg::SAMPLE_W-1:0]   left_out;
  logic signed [gacs_pkg::SAMPLE_W-1:0]   right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

FILE: rtl/gacs_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface gacs_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [gacs_pkg::CFG_IDX_W-1:0]         index;
  logic [gacs_pkg::CFG_DATA_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/gacs_lane.sv
// One channel lane: drive, optional SVF, shaper, delay ring, lowpass and DC highpass.
module gacs_lane #(
  parameter int DELAY_LENGTH = gacs_pkg::DELAY_LENGTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gacs_pkg::lane_ctl_t                  ctl,
  input  gacs_pkg::cfg_regs_t                  cfg,
  input  logic [$clog2(DELAY_LENGTH)-1:0]      ptr,
  input  logic signed [gacs_pkg::X_W-1:0]      x,
  output gacs_pkg::lane_sts_t                  sts,
  output logic signed [gacs_pkg::SAMPLE_W-1:0] y
);

  localparam int AW = $clog2(DELAY_LENGTH);
  localparam int SW = ((AW > gacs_pkg::DELAY_W) ? AW : gacs_pkg::DELAY_W) + 1;
  localparam logic [SW-1:0] DL_S   = SW'(DELAY_LENGTH);
  localparam logic [SW-1:0] LAST_S = SW'(DELAY_LENGTH - 1);
  localparam logic [40:0]   ONE_Q23 = 41'(1) << 23;
  localparam int ACC_W = gacs_pkg::ACC_W;
  localparam int ST_W  = gacs_pkg::ST_W;

  gacs_pkg::lane_state_t state_r, state_nxt;

  // control registers
  logic                    ph_r, ph_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [SW-1:0]           addr_r, addr_nxt;
  logic                    mono_r, mono_nxt;

  // filter state
  logic signed [ST_W-1:0]  h0_r, h0_nxt, h1_r, h1_nxt;
  logic signed [ST_W-1:0]  lp0_r, lp0_nxt, lp1_r, lp1_nxt, lp2_r, lp2_nxt, lp3_r, lp3_nxt;
  logic signed [ST_W-1:0]  dc_r, dc_nxt;

  // per-frame datapath registers
  logic signed [gacs_pkg::XB_W-1:0]     xb_r, xb_nxt;
  logic signed [ACC_W-1:0]              acc_r, acc_nxt;
  logic signed [ST_W-1:0]               a_r, a_nxt;
  logic signed [41:0]                   t_r, t_nxt;
  logic                                 neg_r, neg_nxt;
  logic [41:0]                          rem_r, rem_nxt;
  logic [40:0]                          den_r, den_nxt;
  logic [22:0]                          q_r, q_nxt;
  logic signed [gacs_pkg::SAMPLE_W-1:0] b_r, b_nxt, t1_r, t1_nxt, y_r, y_nxt;
  logic signed [30:0]                   bm_r, bm_nxt;

  // delay ring
  logic [gacs_pkg::SAMPLE_W-1:0]        mem [DELAY_LENGTH];
  logic signed [gacs_pkg::SAMPLE_W-1:0] rd_q;
  logic                                 mem_we, mem_re;
  logic [AW-1:0]                        mem_wa, mem_ra;
  logic [gacs_pkg::SAMPLE_W-1:0]        mem_wd;

  // shared multiplier
  logic signed [gacs_pkg::OPA_W-1:0]    opa;
  logic signed [gacs_pkg::OPB_W-1:0]    opb;
  logic signed [21:0]                   mpa;
  logic signed [49:0]                   prod;
  logic signed [ACC_W-1:0]              term;
  logic                                 mul_st, mul_first;

  // misc combinational
  logic signed [23:0]       bq;
  logic signed [40:0]       a41, mag_s;
  logic [40:0]              mag;
  logic [41:0]              rem2;
  logic signed [ACC_W-1:0]  clip_c, a_w, h1n_w, dcn_w;
  logic signed [ST_W-1:0]   h1n, dcn, lp_sel, lp_prev;
  logic [1:0]               k;
  logic                     soft_mode, red_done;

  assign soft_mode = cfg.tap_delays_and_mode[gacs_pkg::MODE_SOFT_BIT];
  assign k         = cnt_r[1:0];

  // multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_r)
      gacs_pkg::L_DRV: begin
        opa = gacs_pkg::OPA_W'(xb_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.drive_gain});
      end
      gacs_pkg::L_SVF0: begin
        opa = gacs_pkg::OPA_W'(h1_r) + gacs_pkg::OPA_W'(a_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.resonance_coefs[15:0]});
      end
      gacs_pkg::L_SVF1: begin
        opa = gacs_pkg::OPA_W'(h1_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.resonance_coefs[31:16]});
      end
      gacs_pkg::L_SVF2: begin
        opa = t_r;
        opb = gacs_pkg::OPB_W'({1'b0, cfg.resonance_coefs[15:0]});
      end
      gacs_pkg::L_MIX1: begin
        opa = gacs_pkg::OPA_W'(t1_r);
        opb = gacs_pkg::OPB_W'(signed'(cfg.tap_mixes[15:0]));
      end
      gacs_pkg::L_MIX2: begin
        opa = gacs_pkg::OPA_W'(rd_q);
        opb = gacs_pkg::OPB_W'(signed'(cfg.tap_mixes[31:16]));
      end
      gacs_pkg::L_LP0A: begin
        opa = gacs_pkg::OPA_W'(lp0_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.smoothing_coefs[15:0]});
      end
      gacs_pkg::L_LP0B: begin
        opa = gacs_pkg::OPA_W'(bm_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.output_gain});
      end
      gacs_pkg::L_LPK: begin
        opa = gacs_pkg::OPA_W'(lp_sel);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.smoothing_coefs[15:0]});
      end
      gacs_pkg::L_DC: begin
        opa = gacs_pkg::OPA_W'(dc_r) - gacs_pkg::OPA_W'(lp3_r);
        opb = gacs_pkg::OPB_W'({1'b0, cfg.smoothing_coefs[31:16]});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // lowpass stage select for stages one to three
  always_comb begin
    unique case (k)
      2'd1:    begin lp_sel = lp1_r; lp_prev = lp0_r; end
      2'd2:    begin lp_sel = lp2_r; lp_prev = lp1_r; end
      2'd3:    begin lp_sel = lp3_r; lp_prev = lp2_r; end
      default: begin lp_sel = lp0_r; lp_prev = lp0_r; end
    endcase
  end

  // two-pass multiply: high half shifted on phase 0, low half on phase 1
  assign mul_st = (state_r == gacs_pkg::L_DRV)  || (state_r == gacs_pkg::L_SVF0) ||
                  (state_r == gacs_pkg::L_SVF1) || (state_r == gacs_pkg::L_SVF2) ||
                  (state_r == gacs_pkg::L_MIX1) || (state_r == gacs_pkg::L_MIX2) ||
                  (state_r == gacs_pkg::L_LP0A) || (state_r == gacs_pkg::L_LP0B) ||
                  (state_r == gacs_pkg::L_LPK)  || (state_r == gacs_pkg::L_DC);
  assign mul_first = mul_st && (state_r != gacs_pkg::L_MIX2) &&
                     (state_r != gacs_pkg::L_LP0B);
  assign mpa  = ph_r ? 22'(signed'({1'b0, opa[gacs_pkg::SPLIT-1:0]}))
                     : 22'(signed'(opa[gacs_pkg::OPA_W-1:gacs_pkg::SPLIT]));
  assign prod = mpa * opb;
  assign term = ph_r ? ACC_W'(prod) : (ACC_W'(prod) <<< gacs_pkg::SPLIT);

  // shaper helpers
  assign bq     = {cfg.bias_offset, 7'b0};
  assign a41    = 41'(a_r);
  assign mag_s  = a_r[ST_W-1] ? -a41 : a41;
  assign mag    = mag_s;
  assign rem2   = {rem_r[40:0], 1'b0};
  assign clip_c = ACC_W'(signed'({1'b0, cfg.clip_level, 7'b0}));
  assign a_w    = ACC_W'(a_r);
  assign h1n_w  = ACC_W'(h1_r) - gacs_pkg::rnd(acc_r, 15);
  assign h1n    = gacs_pkg::sat40(h1n_w);
  assign dcn_w  = gacs_pkg::rnd(acc_r, 16) + ACC_W'(lp3_r);
  assign dcn    = gacs_pkg::sat40(dcn_w);
  assign red_done = (addr_r < DL_S);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gacs_pkg::L_CLEAR:    if (addr_r == LAST_S) state_nxt = gacs_pkg::L_IDLE;
      gacs_pkg::L_IDLE:     if (ctl.start) state_nxt = gacs_pkg::L_DRV;
      gacs_pkg::L_DRV:      if (ph_r) state_nxt = gacs_pkg::L_DRV_FIN;
      gacs_pkg::L_DRV_FIN:  state_nxt = mono_r ? gacs_pkg::L_SVF0 : gacs_pkg::L_SHAPE;
      gacs_pkg::L_SVF0:     if (ph_r) state_nxt = gacs_pkg::L_SVF0_FIN;
      gacs_pkg::L_SVF0_FIN: state_nxt = gacs_pkg::L_SVF1;
      gacs_pkg::L_SVF1:     if (ph_r) state_nxt = gacs_pkg::L_SVF1_FIN;
      gacs_pkg::L_SVF1_FIN: state_nxt = gacs_pkg::L_SVF2;
      gacs_pkg::L_SVF2:     if (ph_r) state_nxt = gacs_pkg::L_SVF2_FIN;
      gacs_pkg::L_SVF2_FIN: state_nxt = gacs_pkg::L_SHAPE;
      gacs_pkg::L_SHAPE:    state_nxt = soft_mode ? gacs_pkg::L_DIV : gacs_pkg::L_WRITE;
      gacs_pkg::L_DIV:      if (cnt_r == 5'd22) state_nxt = gacs_pkg::L_DIV_FIN;
      gacs_pkg::L_DIV_FIN:  state_nxt = gacs_pkg::L_WRITE;
      gacs_pkg::L_WRITE:    state_nxt = gacs_pkg::L_RED1;
      gacs_pkg::L_RED1:     if (red_done) state_nxt = gacs_pkg::L_ADDR2;
      gacs_pkg::L_ADDR2:    state_nxt = gacs_pkg::L_RED2;
      gacs_pkg::L_RED2:     if (red_done) state_nxt = gacs_pkg::L_MIX1;
      gacs_pkg::L_MIX1:     if (ph_r) state_nxt = gacs_pkg::L_MIX2;
      gacs_pkg::L_MIX2:     if (ph_r) state_nxt = gacs_pkg::L_MIX_FIN;
      gacs_pkg::L_MIX_FIN:  state_nxt = gacs_pkg::L_LP0A;
      gacs_pkg::L_LP0A:     if (ph_r) state_nxt = gacs_pkg::L_LP0B;
      gacs_pkg::L_LP0B:     if (ph_r) state_nxt = gacs_pkg::L_LP0_FIN;
      gacs_pkg::L_LP0_FIN:  state_nxt = gacs_pkg::L_LPK;
      gacs_pkg::L_LPK:      if (ph_r) state_nxt = gacs_pkg::L_LPK_FIN;
      gacs_pkg::L_LPK_FIN:  state_nxt = (k == 2'd3) ? gacs_pkg::L_DC : gacs_pkg::L_LPK;
      gacs_pkg::L_DC:       if (ph_r) state_nxt = gacs_pkg::L_DC_FIN;
      gacs_pkg::L_DC_FIN:   state_nxt = gacs_pkg::L_DONE;
      gacs_pkg::L_DONE:     if (ctl.ack) state_nxt = gacs_pkg::L_IDLE;
      default:              state_nxt = gacs_pkg::L_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    addr_nxt = addr_r;
    mono_nxt = mono_r;
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    lp0_nxt  = lp0_r;
    lp1_nxt  = lp1_r;
    lp2_nxt  = lp2_r;
    lp3_nxt  = lp3_r;
    dc_nxt   = dc_r;
    xb_nxt   = xb_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    t_nxt    = t_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    b_nxt    = b_r;
    t1_nxt   = t1_r;
    bm_nxt   = bm_r;
    y_nxt    = y_r;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = ptr;
    mem_ra   = addr_r[AW-1:0];
    mem_wd   = b_r;

    if (mul_st) begin
      ph_nxt  = ~ph_r;
      acc_nxt = ((mul_first && !ph_r) ? '0 : acc_r) + term;
    end

    unique case (state_r)
      gacs_pkg::L_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = addr_r[AW-1:0];
        mem_wd   = '0;
        addr_nxt = addr_r + SW'(1);
      end
      gacs_pkg::L_IDLE: begin
        ph_nxt = 1'b0;
        if (ctl.start) begin
          xb_nxt   = gacs_pkg::XB_W'(x) + gacs_pkg::XB_W'(bq);
          mono_nxt = ctl.mono;
        end
      end
      gacs_pkg::L_DRV_FIN:  a_nxt = gacs_pkg::sat40(gacs_pkg::rnd(acc_r, 16));
      gacs_pkg::L_SVF0_FIN: h0_nxt = gacs_pkg::sat40(ACC_W'(h0_r) + gacs_pkg::rnd(acc_r, 15));
      gacs_pkg::L_SVF1_FIN: t_nxt = 42'(ACC_W'(h0_r) + gacs_pkg::rnd(acc_r, 15));
      gacs_pkg::L_SVF2_FIN: begin
        h1_nxt = h1n;
        a_nxt  = gacs_pkg::sat40(a_w + ACC_W'(h1n));
      end
      gacs_pkg::L_SHAPE: begin
        neg_nxt = a_r[ST_W-1];
        rem_nxt = {1'b0, mag};
        den_nxt = ONE_Q23 + mag;
        q_nxt   = '0;
        cnt_nxt = '0;
        if (a_w > clip_c)       b_nxt = gacs_pkg::sat24(clip_c);
        else if (a_w < -clip_c) b_nxt = gacs_pkg::sat24(-clip_c);
        else                    b_nxt = gacs_pkg::sat24(a_w);
      end
      gacs_pkg::L_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (rem2 >= {1'b0, den_r}) begin
          rem_nxt = rem2 - {1'b0, den_r};
          q_nxt   = {q_r[21:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          q_nxt   = {q_r[21:0], 1'b0};
        end
      end
      gacs_pkg::L_DIV_FIN: b_nxt = neg_r ? -(24'(q_r)) : 24'(q_r);
      gacs_pkg::L_WRITE: begin
        mem_we   = 1'b1;
        addr_nxt = SW'(ptr) + SW'(cfg.tap_delays_and_mode[9:0]);
      end
      gacs_pkg::L_RED1, gacs_pkg::L_RED2: begin
        if (red_done) mem_re = 1'b1;
        else          addr_nxt = addr_r - DL_S;
      end
      gacs_pkg::L_ADDR2: begin
        t1_nxt   = rd_q;
        addr_nxt = SW'(ptr) + SW'(cfg.tap_delays_and_mode[19:10]);
      end
      gacs_pkg::L_MIX_FIN: bm_nxt = 31'(ACC_W'(b_r) + gacs_pkg::rnd(acc_r, 12));
      gacs_pkg::L_LP0_FIN: begin
        lp0_nxt = gacs_pkg::sat40(gacs_pkg::rnd(acc_r, 16));
        cnt_nxt = 5'd1;
      end
      gacs_pkg::L_LPK_FIN: begin
        cnt_nxt = cnt_r + 5'd1;
        unique case (k)
          2'd1:    lp1_nxt = gacs_pkg::sat40(gacs_pkg::rnd(acc_r, 16) + ACC_W'(lp_prev));
          2'd2:    lp2_nxt = gacs_pkg::sat40(gacs_pkg::rnd(acc_r, 16) + ACC_W'(lp_prev));
          2'd3:    lp3_nxt = gacs_pkg::sat40(gacs_pkg::rnd(acc_r, 16) + ACC_W'(lp_prev));
          default: lp1_nxt = lp1_r;
        endcase
      end
      gacs_pkg::L_DC_FIN: begin
        dc_nxt = dcn;
        y_nxt  = gacs_pkg::sat24(ACC_W'(lp3_r) - ACC_W'(dcn));
      end
      default: ;
    endcase
  end

  // control and filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gacs_pkg::L_CLEAR;
      ph_r    <= 1'b0;
      cnt_r   <= '0;
      addr_r  <= '0;
      mono_r  <= 1'b0;
      h0_r    <= '0;
      h1_r    <= '0;
      lp0_r   <= '0;
      lp1_r   <= '0;
      lp2_r   <= '0;
      lp3_r   <= '0;
      dc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      cnt_r   <= cnt_nxt;
      addr_r  <= addr_nxt;
      mono_r  <= mono_nxt;
      h0_r    <= h0_nxt;
      h1_r    <= h1_nxt;
      lp0_r   <= lp0_nxt;
      lp1_r   <= lp1_nxt;
      lp2_r   <= lp2_nxt;
      lp3_r   <= lp3_nxt;
      dc_r    <= dc_nxt;
    end
  end

  // per-frame payload registers
  always_ff @(posedge clk) begin
    xb_r  <= xb_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    t_r   <= t_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    b_r   <= b_nxt;
    t1_r  <= t1_nxt;
    bm_r  <= bm_nxt;
    y_r   <= y_nxt;
  end

  // delay ring, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  assign sts.idle = (state_r == gacs_pkg::L_IDLE);
  assign sts.done = (state_r == gacs_pkg::L_DONE);
  assign y        = y_r;

  // ring accesses stay inside the ring
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (SW'(mem_wa) < DL_S))
    else $error("ring write address out of range");
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (SW'(mem_ra) < DL_S))
    else $error("ring read address out of range");
  // a frame only starts on an idle lane
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (state_r == gacs_pkg::L_IDLE))
    else $error("lane started while busy");
  // divider finishes after 23 quotient bits
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gacs_pkg::L_DIV) |-> (cnt_r <= 5'd22))
    else $error("divider overran");

endmodule

FILE: rtl/gacs_merge.sv
// Merge stage: combines the lane results into the registered output channel.
module gacs_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gacs_pkg::lane_sts_t                  sts0,
  input  gacs_pkg::lane_sts_t                  sts1,
  input  logic signed [gacs_pkg::SAMPLE_W-1:0] y0,
  input  logic signed [gacs_pkg::SAMPLE_W-1:0] y1,
  input  logic                                 mono,
  output logic                                 ack,
  gacs_out_if.source                           out_ch
);

  logic                                 valid_r, valid_nxt;
  logic signed [gacs_pkg::SAMPLE_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic                                 ready_all;

  // take the result once every active lane is done and the slot is free
  assign ready_all = sts0.done && (mono || sts1.done);
  assign ack       = ready_all && (!valid_r || out_ch.ready);

  always_comb begin
    valid_nxt = valid_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    if (ack) begin
      valid_nxt = 1'b1;
      left_nxt  = y0;
      right_nxt = mono ? y0 : y1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;

endmodule

FILE: rtl/guitar_amp_cabinet_simulator.sv
// Top level of the guitar amp and speaker cabinet simulator.
// One stereo frame is processed at a time by two channel lanes, each running a
// sequencer around one shared two-pass multiplier, its own delay ring memory and
// the filter states. A new frame is taken once both lanes are idle and the last
// result is in the output register; mono mode adds the three state-variable
// filter products and soft clipping the one-bit-per-cycle soft-clip divider. The
// result is presented in the same cycle as the next frame can be taken. Each tap
// whose ring address runs past the end of the ring adds a reduction step per
// wrap: at most one wrap per tap when DELAY_LENGTH is 1024 or more, more when it
// is shorter. After reset every ring word is cleared before the first frame is
// taken; configuration writes are accepted at any time. A finished frame waits
// in the output register while the next frame is already being processed.
module guitar_amp_cabinet_simulator #(
  parameter int DELAY_LENGTH = gacs_pkg::DELAY_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gacs_in_if.sink    in_ch,
  gacs_out_if.source out_ch,
  gacs_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(DELAY_LENGTH);

  gacs_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic                busy_r, busy_nxt;
  logic                mono_r, mono_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;

  gacs_pkg::lane_ctl_t ctl0, ctl1;
  gacs_pkg::lane_sts_t sts0, sts1;
  logic signed [gacs_pkg::X_W-1:0]      x0, x1;
  logic signed [gacs_pkg::SAMPLE_W-1:0] y0, y1;
  logic                                 accept, ack, stereo;

  // configuration writes
  assign cfg_ch.ready = 1'b1;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gacs_pkg::REG_DRIVE_GAIN:  cfg_nxt.drive_gain          = cfg_ch.data[26:0];
        gacs_pkg::REG_BIAS_OFFSET: cfg_nxt.bias_offset         = cfg_ch.data[16:0];
        gacs_pkg::REG_CLIP_LEVEL:  cfg_nxt.clip_level          = cfg_ch.data[19:0];
        gacs_pkg::REG_OUTPUT_GAIN: cfg_nxt.output_gain         = cfg_ch.data[23:0];
        gacs_pkg::REG_SMOOTHING:   cfg_nxt.smoothing_coefs     = cfg_ch.data;
        gacs_pkg::REG_TAP_MIXES:   cfg_nxt.tap_mixes           = cfg_ch.data;
        gacs_pkg::REG_TAP_MODE:    cfg_nxt.tap_delays_and_mode = cfg_ch.data[21:0];
        gacs_pkg::REG_RESONANCE:   cfg_nxt.resonance_coefs     = cfg_ch.data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // frame request and lane start
  assign stereo      = cfg_r.tap_delays_and_mode[gacs_pkg::MODE_STEREO_BIT];
  assign in_ch.ready = !busy_r && sts0.idle && sts1.idle;
  assign accept      = in_ch.valid && in_ch.ready;

  assign x0 = stereo ? gacs_pkg::X_W'(in_ch.left_sample)
                     : gacs_pkg::X_W'(in_ch.left_sample) + gacs_pkg::X_W'(in_ch.right_sample);
  assign x1 = gacs_pkg::X_W'(in_ch.right_sample);

  assign ctl0.start = accept;
  assign ctl0.mono  = !stereo;
  assign ctl0.ack   = ack;
  assign ctl1.start = accept && stereo;
  assign ctl1.mono  = 1'b0;
  assign ctl1.ack   = ack;

  // busy flag, mode latch and ring pointer
  always_comb begin
    busy_nxt = busy_r;
    mono_nxt = mono_r;
    ptr_nxt  = ptr_r;
    if (accept) begin
      busy_nxt = 1'b1;
      mono_nxt = !stereo;
    end else if (ack) begin
      busy_nxt = 1'b0;
      ptr_nxt  = (ptr_r == '0) ? AW'(DELAY_LENGTH - 1) : ptr_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_gain          <= 27'd65536;
      cfg_r.bias_offset         <= '0;
      cfg_r.clip_level          <= 20'd327680;
      cfg_r.output_gain         <= 24'd65536;
      cfg_r.smoothing_coefs     <= '0;
      cfg_r.tap_mixes           <= '0;
      cfg_r.tap_delays_and_mode <= '0;
      cfg_r.resonance_coefs     <= '0;
      busy_r                    <= 1'b0;
      mono_r                    <= 1'b0;
      ptr_r                     <= '0;
    end else begin
      cfg_r  <= cfg_nxt;
      busy_r <= busy_nxt;
      mono_r <= mono_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  gacs_lane #(.DELAY_LENGTH(DELAY_LENGTH)) u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl0),
    .cfg   (cfg_r),
    .ptr   (ptr_r),
    .x     (x0),
    .sts   (sts0),
    .y     (y0)
  );

  gacs_lane #(.DELAY_LENGTH(DELAY_LENGTH)) u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl1),
    .cfg   (cfg_r),
    .ptr   (ptr_r),
    .x     (x1),
    .sts   (sts1),
    .y     (y1)
  );

  gacs_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .sts0   (sts0),
    .sts1   (sts1),
    .y0     (y0),
    .y1     (y1),
    .mono   (mono_r),
    .ack    (ack),
    .out_ch (out_ch)
  );

  // a result is only taken for a frame in flight
  a_ack_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ack |-> busy_r)
    else $error("result without a frame in flight");
  // a taken result shows up on the output channel
  a_ack_out: assert property (@(posedge clk) disable iff (!rst_n)
    ack |=> out_ch.valid)
    else $error("taken result not presented");
  // ring pointer stays inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_r) < DELAY_LENGTH)
    else $error("ring pointer out of range");

endmodule
